@@ sv/talc_pkg.sv @@
// shared types and constants for the touch alarm led controller
`default_nettype none

package talc_pkg;

   // field widths
   localparam int COUNT_W = 16;
   localparam int THR_W   = 16;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 8;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1280;

   // configuration register indexes
   localparam logic CSR_THR_RIGHT = 1'b0;
   localparam logic CSR_THR_LEFT  = 1'b1;

   // alarm mode codes
   localparam logic [1:0] MODE_ARMED    = 2'd0;
   localparam logic [1:0] MODE_DISARMED = 2'd1;
   localparam logic [1:0] MODE_ALARM    = 2'd2;

   // preset codes
   localparam logic [1:0] PRESET_NONE  = 2'd0;
   localparam logic [1:0] PRESET_OFF   = 2'd1;
   localparam logic [1:0] PRESET_FIRST = 2'd2;

   // electrode masks and blink periods
   localparam logic [1:0] BIT_RIGHT = 2'b01;
   localparam logic [1:0] BIT_LEFT  = 2'b10;
   localparam logic [1:0] BIT_BOTH  = 2'b11;

   localparam logic [7:0] BLINK_ARMED    = 8'd5;
   localparam logic [7:0] BLINK_DISARMED = 8'd10;
   localparam logic [7:0] BLINK_ALARM    = 8'd2;

   // controller state carried from request to request
   typedef struct packed {
      logic       scanning_left;
      logic [1:0] touched;
      logic [1:0] scanned;
      logic [1:0] alarm_latch;
      logic [2:0] tick_prescale;
      logic [7:0] blink_count;
      logic [1:0] preset_pending;
      logic [1:0] led_bits;
   } talc_state_type;

   // one result item
   typedef struct packed {
      logic [1:0] touched_bits;
      logic       scan_electrode;
      logic       start_scan;
      logic       led_second;
      logic       led_first;
   } talc_result_type;

endpackage

`default_nettype wire

@@ sv/talc_step.sv @@
// next-state and result logic for one tick request
`default_nettype none

module talc_step
   import talc_pkg::*;
#(
   parameter int LED_PRESCALE = 5
) (
   input  wire talc_state_type        cur_state,
   input  wire logic [THR_W-1:0]      threshold_right,
   input  wire logic [THR_W-1:0]      threshold_left,
   input  wire logic                  scan_done,
   input  wire logic [COUNT_W-1:0]    scan_count,
   input  wire logic [1:0]            alarm_mode,
   input  wire logic [1:0]            start_over,
   input  wire logic                  clear_latch,
   output talc_state_type             nxt_state,
   output talc_result_type            result
);

   localparam logic [2:0] PRESCALE_CNT = 3'(LED_PRESCALE);

   // led pattern update: both toggle, one toggles with the other off, or both off
   function automatic logic [1:0] led_pattern(input logic [1:0] led, input logic [1:0] pat);
      logic [1:0] res;
      begin
         case (pat)
            BIT_BOTH:  res = led ^ BIT_BOTH;
            BIT_RIGHT: res = (led ^ BIT_RIGHT) & BIT_RIGHT;
            BIT_LEFT:  res = (led ^ BIT_LEFT) & BIT_LEFT;
            default:   res = 2'b00;
         endcase
         return res;
      end
   endfunction

   talc_state_type   st;
   logic             start;
   logic [1:0]       sel;
   logic [THR_W-1:0] thr;
   logic [2:0]       tick_inc;
   logic [7:0]       blink_inc;

   always_comb begin
      st        = cur_state;
      start     = 1'b0;
      sel       = BIT_RIGHT;
      thr       = threshold_right;
      blink_inc = cur_state.blink_count + 8'd1;

      // latch clear comes first
      if (clear_latch) begin
         st.alarm_latch = 2'b00;
      end

      // sensor step, frozen while the latch is full
      if (st.alarm_latch != BIT_BOTH && scan_done) begin
         if (cur_state.scanning_left) begin
            sel = BIT_LEFT;
            thr = threshold_left;
         end
         st.scanned = st.scanned | sel;
         if (scan_count > thr) begin
            st.touched = st.touched | sel;
         end else begin
            st.touched = st.touched & ~sel;
         end
         st.scanning_left = ~cur_state.scanning_left;
         start = 1'b1;
      end

      // preset capture
      if (start_over == PRESET_OFF || start_over == PRESET_FIRST) begin
         st.preset_pending = start_over;
      end

      // led step prescaler
      tick_inc         = cur_state.tick_prescale + 3'd1;
      st.tick_prescale = tick_inc;
      if (tick_inc >= PRESCALE_CNT) begin
         st.tick_prescale = 3'd0;

         case (st.preset_pending)
            PRESET_OFF:   st.led_bits = 2'b00;
            PRESET_FIRST: st.led_bits = BIT_RIGHT;
            default:      ;
         endcase
         st.preset_pending = PRESET_NONE;

         case (alarm_mode)
            MODE_ARMED: begin
               st.blink_count = blink_inc;
               if (blink_inc >= BLINK_ARMED) begin
                  st.blink_count = 8'd0;
                  st.led_bits    = st.led_bits ^ BIT_BOTH;
               end
            end
            MODE_DISARMED: begin
               st.blink_count = blink_inc;
               if (blink_inc >= BLINK_DISARMED && st.scanned == BIT_BOTH) begin
                  st.blink_count = 8'd0;
                  st.led_bits    = led_pattern(st.led_bits, st.touched);
                  st.scanned     = 2'b00;
               end
            end
            MODE_ALARM: begin
               if (st.alarm_latch != BIT_BOTH && st.scanned == BIT_BOTH) begin
                  st.alarm_latch = st.alarm_latch | st.touched;
                  st.scanned     = 2'b00;
               end
               st.blink_count = blink_inc;
               if (blink_inc >= BLINK_ALARM) begin
                  st.blink_count = 8'd0;
                  if (st.alarm_latch != 2'b00) begin
                     st.led_bits = led_pattern(st.led_bits, st.alarm_latch);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign nxt_state             = st;
   assign result.led_first      = st.led_bits[0];
   assign result.led_second     = st.led_bits[1];
   assign result.start_scan     = start;
   assign result.scan_electrode = st.scanning_left;
   assign result.touched_bits   = st.touched;

endmodule

`default_nettype wire

@@ sv/touch_alarm_led_controller_core.sv @@
// top level of the touch alarm led controller
//
// One request is one tick: it carries the scan status of the current
// electrode, the alarm mode, a preset request and a latch clear. Every
// accepted request yields exactly one response with the two led states,
// the scan start strobe, the electrode now being scanned and the touched bits.
// The csr port writes the right (index 0) and left (index 1) touch thresholds;
// write them only while no request is in flight.
// A response is registered in the output register, or in the skid register
// on a stall. Throughput is one request per cycle while req_tready is high,
// set by the single state register that the tick logic updates per accept.
// The response side holds a two-entry buffer (output register plus skid
// register); when the receiver stalls, one more request is still taken
// and req_tready drops only once both entries are full.
// Reset clears all tick state and both buffer entries and reloads the
// thresholds with 1280.
`default_nettype none

module touch_alarm_led_controller_core
   import talc_pkg::*;
#(
   parameter int LED_PRESCALE = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request: [0] scan_done, [16:1] scan_count, [18:17] alarm_mode,
   // [20:19] start_over, [21] clear_latch, [23:22] zero
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // response: [0] led_first, [1] led_second, [2] start_scan,
   // [3] scan_electrode, [5:4] touched_bits, [7:6] zero
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [RSP_W-1:0] rsp_tdata,
   // threshold writes
   input  wire logic             csr_we,
   input  wire logic             csr_addr,
   input  wire logic [THR_W-1:0] csr_wdata
);

   talc_state_type   state_ff;
   talc_state_type   state_in;
   talc_result_type  result;
   logic [THR_W-1:0] thr_right_ff;
   logic [THR_W-1:0] thr_left_ff;
   logic             req_accept;
   logic             rsp_valid_ff;
   logic             skid_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] skid_data_ff;
   logic [RSP_W-1:0] new_data;

   assign req_accept = req_tvalid && req_tready;

   // tick logic
   talc_step #(
      .LED_PRESCALE (LED_PRESCALE)
   ) u_step (
      .cur_state       (state_ff),
      .threshold_right (thr_right_ff),
      .threshold_left  (thr_left_ff),
      .scan_done       (req_tdata[0]),
      .scan_count      (req_tdata[16:1]),
      .alarm_mode      (req_tdata[18:17]),
      .start_over      (req_tdata[20:19]),
      .clear_latch     (req_tdata[21]),
      .nxt_state       (state_in),
      .result          (result)
   );

   assign new_data = {2'b00, result};

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_right_ff <= THRESHOLD_RESET;
         thr_left_ff  <= THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_THR_RIGHT: thr_right_ff <= csr_wdata;
            CSR_THR_LEFT:  thr_left_ff  <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // tick state, updated on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_tready) begin
         if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_tready) begin
         if (req_accept) begin
            skid_data_ff <= new_data;
         end
      end else if (skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end else if (req_accept) begin
         rsp_data_ff <= new_data;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/talc_checker.sv @@
// port-level checks for the touch alarm led controller, bound to the top level
`default_nettype none

module talc_checker
   import talc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // reset empties the response buffer
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // an accepted request with room at the output shows up next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("response missing one cycle after request");

   // backpressure only when the output register is also full
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with empty output");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] == 2'b00)
      else $error("response padding not zero");

endmodule

bind touch_alarm_led_controller_core talc_checker u_talc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
